// ===== design/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, constants and fixed-point helpers for the rigid transform
// inverse block.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int IN_W      = 384;
    localparam int OUT_W     = 136;
    localparam int LANES     = 3;
    localparam int DIV_STEPS = 33;

    localparam logic signed [31:0] DET_THR_RESET = 32'sd1073742;

    typedef struct packed {
        logic                   v;
        logic [1:0]             row;
        logic                   refuse;
        logic [LANES-1:0]       neg;
        logic [LANES-1:0]       ovf;
        logic [34:0]            ud;
        logic [LANES-1:0][31:0] t;
    } div_side_t;

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sh007FFFFFFF) begin
            return 32'h7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd536870912;
        return 34'(s >>> 30);
    endfunction

    function automatic logic [31:0] minor_q30(input logic signed [63:0] p,
                                              input logic signed [63:0] q);
        logic signed [64:0] d;
        d = 65'(p) - 65'(q) + 65'sd536870912;
        return sat32(40'(d >>> 30));
    endfunction

endpackage

// ===== design/rigid_transform_inverse_top.sv =====
// ----------------------------------------------------------------------------
// rigid_transform_inverse_top
// Inverts a rigid homogeneous transform: rotation by cofactors over the
// determinant, translation as -R^-1 * t, one row per result item.
// ----------------------------------------------------------------------------
// Takes a new item while the last row beat of the previous one issues. Each
// item is split into three row beats that enter the pipeline on consecutive
// cycles unless the result side stalls; while it does not, the result channel
// carries one row per cycle. The wait for the first row of an item is set
// mostly by the 33-stage restoring dividers (three lanes, one bit per stage).
// A refused item leaves only its first beat as a result (ok low, last high).
// A stall on the result side holds every stage in place.
module rigid_transform_inverse_top import rti_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // rot_r0c0..rot_r2c2, trans_x, trans_y, trans_z (32 bits each)
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // row_index[1:0], inv_c0, inv_c1, inv_c2, inv_trans (32 each), zero pad
    output logic [OUT_W-1:0] m_tdata,
    // ok
    output logic [0:0]       m_tuser,
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);

    logic              adv;
    logic signed [31:0] thr_reg;

    // issue stage
    logic [31:0] rot_reg [9];
    logic [31:0] trans_reg [3];
    logic        busy_reg;
    logic [1:0]  beat_reg;
    logic        s_acc;

    // stage 1: products
    logic               v1_reg;
    logic [1:0]         row1_reg;
    logic signed [63:0] pa_next [3], pb_next [3], qa_next [3], qb_next [3];
    logic signed [63:0] pa_reg [3], pb_reg [3], qa_reg [3], qb_reg [3];
    logic [31:0]        r0_1_reg [3], t1_reg [3];

    // stage 2: minors
    logic        v2_reg;
    logic [1:0]  row2_reg;
    logic [31:0] cm2_reg [3], rm2_reg [3], r0_2_reg [3], t2_reg [3];

    // stage 3: determinant products
    logic               v3_reg;
    logic [1:0]         row3_reg;
    logic signed [63:0] dp3_reg [3];
    logic [31:0]        cm3_reg [3], t3_reg [3];

    // stage 4: determinant, cofactors
    logic               v4_reg;
    logic [1:0]         row4_reg;
    logic signed [34:0] det4_reg;
    logic               ref4_reg;
    logic signed [32:0] cof4_reg [3];
    logic [31:0]        t4_reg [3];
    logic signed [34:0] det_next;

    // divider stages
    logic [35:0] drem_reg  [LANES][DIV_STEPS+1];
    logic [32:0] dnum_reg  [LANES][DIV_STEPS+1];
    logic [32:0] dquo_reg  [LANES][DIV_STEPS+1];
    logic [35:0] drem_next [LANES][DIV_STEPS+1];
    logic [32:0] dnum_next [LANES][DIV_STEPS+1];
    logic [32:0] dquo_next [LANES][DIV_STEPS+1];
    div_side_t   dside_reg [DIV_STEPS+1];
    div_side_t   dside_next [DIV_STEPS+1];

    // saturate stage
    logic        vs_reg, refs_reg;
    logic [1:0]  rows_reg;
    logic [31:0] inv_reg [3], ts_reg [3], inv_next [3];

    // translation product stage
    logic               vt_reg, reft_reg;
    logic [1:0]         rowt_reg;
    logic [31:0]        invt_reg [3];
    logic signed [63:0] tp_reg [3];

    // output register
    logic        m_tvalid_reg;
    logic [1:0]  o_row_reg;
    logic [31:0] o_c0_reg, o_c1_reg, o_c2_reg, o_tr_reg;
    logic        o_ok_reg, o_last_reg;
    logic signed [35:0] tacc;
    logic [31:0]        tr_next;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv && (!busy_reg || beat_reg == 2'd2);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= DET_THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // issue: one row beat per cycle while the pipeline advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= 2'd0;
        end else if (adv) begin
            if (busy_reg && beat_reg != 2'd2) begin
                beat_reg <= beat_reg + 2'd1;
            end else begin
                busy_reg <= s_acc;
                beat_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int k = 0; k < 9; k++) begin
                rot_reg[k] <= s_tdata[32*k +: 32];
            end
            for (int k = 0; k < 3; k++) begin
                trans_reg[k] <= s_tdata[288 + 32*k +: 32];
            end
        end
    end

    // stage 1 operands: columns other than the beat's row
    logic [1:0]  ca, cb;
    logic [31:0] va [3], vb [3];

    always_comb begin
        case (beat_reg)
            2'd0: begin
                ca = 2'd1;
                cb = 2'd2;
            end
            2'd1: begin
                ca = 2'd0;
                cb = 2'd2;
            end
            default: begin
                ca = 2'd0;
                cb = 2'd1;
            end
        endcase
        for (int r = 0; r < 3; r++) begin
            va[r] = rot_reg[4'(3*r) + {2'b00, ca}];
            vb[r] = rot_reg[4'(3*r) + {2'b00, cb}];
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_prod
        localparam int RA = (j == 0) ? 1 : 0;
        localparam int RB = (j == 2) ? 1 : 2;
        localparam int CA = (j == 0) ? 1 : 0;
        localparam int CB = (j == 2) ? 1 : 2;
        assign pa_next[j] = $signed(va[RA]) * $signed(vb[RB]);
        assign pb_next[j] = $signed(vb[RA]) * $signed(va[RB]);
        assign qa_next[j] = $signed(rot_reg[3+CA]) * $signed(rot_reg[6+CB]);
        assign qb_next[j] = $signed(rot_reg[3+CB]) * $signed(rot_reg[6+CA]);
    end

    always_comb begin
        det_next = 35'(rnd_q30(dp3_reg[0])) - 35'(rnd_q30(dp3_reg[1]))
                 + 35'(rnd_q30(dp3_reg[2]));
    end

    // front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            row1_reg <= beat_reg;
            row2_reg <= row1_reg;
            row3_reg <= row2_reg;
            row4_reg <= row3_reg;
            for (int j = 0; j < 3; j++) begin
                pa_reg[j]   <= pa_next[j];
                pb_reg[j]   <= pb_next[j];
                qa_reg[j]   <= qa_next[j];
                qb_reg[j]   <= qb_next[j];
                r0_1_reg[j] <= rot_reg[j];
                t1_reg[j]   <= trans_reg[j];

                cm2_reg[j]  <= minor_q30(pa_reg[j], pb_reg[j]);
                rm2_reg[j]  <= minor_q30(qa_reg[j], qb_reg[j]);
                r0_2_reg[j] <= r0_1_reg[j];
                t2_reg[j]   <= t1_reg[j];

                dp3_reg[j]  <= $signed(r0_2_reg[j]) * $signed(rm2_reg[j]);
                cm3_reg[j]  <= cm2_reg[j];
                t3_reg[j]   <= t2_reg[j];

                cof4_reg[j] <= (row3_reg[0] ^ j[0]) ? -33'($signed(cm3_reg[j]))
                                                    : 33'($signed(cm3_reg[j]));
                t4_reg[j]   <= t3_reg[j];
            end
            det4_reg <= det_next;
            ref4_reg <= (det_next == 35'sd0) || (det_next < 35'(thr_reg));
        end
    end

    // divider setup and restoring steps
    always_comb begin
        logic [34:0] ud;
        logic [32:0] ucof;
        logic [62:0] num;
        logic [35:0] sh;
        ud = det4_reg[34] ? 35'(-det4_reg) : 35'(det4_reg);
        dside_next[0].v      = v4_reg;
        dside_next[0].row    = row4_reg;
        dside_next[0].refuse = ref4_reg;
        dside_next[0].ud     = ud;
        for (int l = 0; l < LANES; l++) begin
            ucof = cof4_reg[l][32] ? 33'(-cof4_reg[l]) : 33'(cof4_reg[l]);
            num  = {ucof, 30'd0} + {28'd0, ud[34:1]};
            dside_next[0].neg[l] = cof4_reg[l][32] ^ det4_reg[34];
            dside_next[0].ovf[l] = {5'd0, num[62:33]} >= ud;
            dside_next[0].t[l]   = t4_reg[l];
            drem_next[l][0] = {6'd0, num[62:33]};
            dnum_next[l][0] = num[32:0];
            dquo_next[l][0] = 33'd0;
        end
        for (int s = 1; s <= DIV_STEPS; s++) begin
            dside_next[s] = dside_reg[s-1];
            for (int l = 0; l < LANES; l++) begin
                sh = {drem_reg[l][s-1][34:0], dnum_reg[l][s-1][32]};
                dnum_next[l][s] = {dnum_reg[l][s-1][31:0], 1'b0};
                if (sh >= {1'b0, dside_reg[s-1].ud}) begin
                    drem_next[l][s] = sh - {1'b0, dside_reg[s-1].ud};
                    dquo_next[l][s] = {dquo_reg[l][s-1][31:0], 1'b1};
                end else begin
                    drem_next[l][s] = sh;
                    dquo_next[l][s] = {dquo_reg[l][s-1][31:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= DIV_STEPS; s++) begin
                dside_reg[s].v <= 1'b0;
            end
        end else if (adv) begin
            for (int s = 0; s <= DIV_STEPS; s++) begin
                dside_reg[s] <= dside_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                for (int s = 0; s <= DIV_STEPS; s++) begin
                    drem_reg[l][s] <= drem_next[l][s];
                    dnum_reg[l][s] <= dnum_next[l][s];
                    dquo_reg[l][s] <= dquo_next[l][s];
                end
            end
        end
    end

    // saturate quotients
    always_comb begin
        logic [32:0] q;
        for (int l = 0; l < LANES; l++) begin
            q = dquo_reg[l][DIV_STEPS];
            if (!dside_reg[DIV_STEPS].neg[l]) begin
                if (dside_reg[DIV_STEPS].ovf[l] || q > 33'h07FFFFFFF) begin
                    inv_next[l] = 32'h7FFFFFFF;
                end else begin
                    inv_next[l] = q[31:0];
                end
            end else begin
                if (dside_reg[DIV_STEPS].ovf[l] || q > 33'h080000000) begin
                    inv_next[l] = 32'h80000000;
                end else begin
                    inv_next[l] = 32'd0 - q[31:0];
                end
            end
        end
    end

    always_comb begin
        tacc = 36'(rnd_q30(tp_reg[0])) + 36'(rnd_q30(tp_reg[1]))
             + 36'(rnd_q30(tp_reg[2]));
        tr_next = sat32(40'(-37'(tacc)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg       <= 1'b0;
            vt_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vs_reg       <= dside_reg[DIV_STEPS].v;
            vt_reg       <= vs_reg;
            // drop the later beats of a refused item
            m_tvalid_reg <= vt_reg && !(reft_reg && rowt_reg != 2'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rows_reg <= dside_reg[DIV_STEPS].row;
            refs_reg <= dside_reg[DIV_STEPS].refuse;
            rowt_reg <= rows_reg;
            reft_reg <= refs_reg;
            for (int j = 0; j < 3; j++) begin
                inv_reg[j]  <= inv_next[j];
                ts_reg[j]   <= dside_reg[DIV_STEPS].t[j];
                invt_reg[j] <= inv_reg[j];
                tp_reg[j]   <= $signed(inv_reg[j]) * $signed(ts_reg[j]);
            end
            if (reft_reg) begin
                o_row_reg  <= 2'd0;
                o_c0_reg   <= 32'd0;
                o_c1_reg   <= 32'd0;
                o_c2_reg   <= 32'd0;
                o_tr_reg   <= 32'd0;
                o_ok_reg   <= 1'b0;
                o_last_reg <= 1'b1;
            end else begin
                o_row_reg  <= rowt_reg;
                o_c0_reg   <= invt_reg[0];
                o_c1_reg   <= invt_reg[1];
                o_c2_reg   <= invt_reg[2];
                o_tr_reg   <= tr_next;
                o_ok_reg   <= 1'b1;
                o_last_reg <= rowt_reg == 2'd2;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, o_tr_reg, o_c2_reg, o_c1_reg, o_c0_reg, o_row_reg};
    assign m_tuser  = o_ok_reg;
    assign m_tlast  = o_last_reg;

endmodule
